// ===== hdl/mrpt_pkg.sv =====
// Shared widths and payload types for the Miller-Rabin primality test block.
package mrpt_pkg;

  localparam int CAND_W     = 63;
  localparam int CAND_EXT_W = 64;
  localparam int SEED_W     = 31;

  typedef logic [CAND_W-1:0] cand_t;
  typedef logic [SEED_W-1:0] seed_t;

endpackage

// ===== hdl/mrpt_if.sv =====
// Valid/ready channel interfaces for the candidate input and the verdict output.
interface mrpt_in_if import mrpt_pkg::*;;
  logic  valid;
  logic  ready;
  cand_t candidate;
  seed_t witness_seed;
  logic  last_round;

  modport source (output valid, output candidate, output witness_seed, output last_round,
                  input ready);
  modport sink (input valid, input candidate, input witness_seed, input last_round,
                output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic probably_prime;
  logic final_res;

  modport source (output valid, output probably_prime, output final_res, input ready);
  modport sink (input valid, input probably_prime, input final_res, output ready);
endinterface

// ===== hdl/miller_rabin_primality_test.sv =====
// One Miller-Rabin witness round per input item, built around one shared modular adder.
//
// Usage: the input channel in_chan carries a candidate, a witness seed and a last-round
// flag; the output channel out_chan returns one verdict per item. probably_prime is 1
// while no round of the current test has failed; final_res repeats last_round. After
// the last round the running verdict returns to 1 for the next candidate.
// A candidate below 2 or even (other than 2) goes from S_CHK straight to S_FIN. Other
// candidates reduce the seed modulo p-1 in S_DIV, strip the factors of two from p-1 in
// S_ODD, then do one modular multiply per set exponent bit and per squaring. Each
// multiply is a shift-add loop of one doubling per multiplier bit and one modular add
// per set multiplier bit. Every step of the seed reduction and of each multiply uses
// the single modular add/compare unit; one item is in work at a time.
// in_chan.ready is high only while the block is idle. A finished verdict sits in an
// output register; the next item may be accepted while it waits, and the block holds
// its next verdict until the receiver has taken the previous one.
// Reset (synchronous, active low) empties the output register, idles the sequencer and
// sets the running verdict to 1.
module miller_rabin_primality_test import mrpt_pkg::*; #(
  parameter int NUM_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  mrpt_in_if.sink     in_chan,
  mrpt_out_if.source  out_chan
);

  localparam int W     = NUM_WIDTH;
  localparam int CNT_W = $clog2(SEED_W);

  localparam logic [W-1:0]     ONE      = W'(1);
  localparam logic [W-1:0]     TWO      = W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEED_W - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ODD   = 4'd3;
  localparam logic [3:0] S_POW   = 4'd4;
  localparam logic [3:0] S_POWSQ = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_SQCHK = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic DST_ACC = 1'b0;
  localparam logic DST_RUN = 1'b1;

  logic [3:0]       state_r, ret_r;
  logic [W-1:0]     p_r, pm1_r, e_r, exp_r;
  logic [W-1:0]     pw_acc_r, pw_run_r;
  logic [W-1:0]     mm_acc_r, mm_run_r, mm_b_r;
  logic             ph_r, dest_r;
  seed_t            seed_r;
  logic [CNT_W-1:0] cnt_r;
  logic             last_r, verd_r, still_r;
  logic             out_valid_r, pp_r, fin_r;

  logic [CAND_EXT_W-1:0] cand_ext;
  logic                  in_xfer;
  logic                  mm_add;
  logic [W-1:0]          au_x, au_y, au_m, au_res;
  logic                  au_cin;
  logic [W:0]            au_sum, au_diff;
  logic                  au_ge;

  assign cand_ext = {1'b0, in_chan.candidate};
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer = in_chan.valid && in_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.probably_prime = pp_r;
  assign out_chan.final_res      = fin_r;

  // During a multiply the accumulate step runs before the doubling of the same bit.
  assign mm_add = !ph_r && mm_b_r[0];

  // Shared unit: (x + y + cin) mod m, valid for x, y < m.
  always_comb begin
    if (state_r == S_DIV) begin
      au_x   = pw_run_r;
      au_y   = pw_run_r;
      au_cin = seed_r[cnt_r];
      au_m   = pm1_r;
    end else begin
      au_x   = mm_add ? mm_acc_r : mm_run_r;
      au_y   = mm_run_r;
      au_cin = 1'b0;
      au_m   = p_r;
    end
  end

  assign au_sum  = {1'b0, au_x} + {1'b0, au_y} + (W+1)'(au_cin);
  assign au_ge   = au_sum >= {1'b0, au_m};
  assign au_diff = au_sum - {1'b0, au_m};
  assign au_res  = au_ge ? au_diff[W-1:0] : au_sum[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      still_r     <= 1'b1;
    end else begin
      // In S_FIN a verdict leaving in this cycle is replaced by the new one below.
      if (out_valid_r && out_chan.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            p_r     <= cand_ext[W-1:0];
            seed_r  <= in_chan.witness_seed;
            last_r  <= in_chan.last_round;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (p_r[W-1:1] == '0 || (!p_r[0] && p_r != TWO)) begin
            verd_r  <= 1'b0;
            state_r <= S_FIN;
          end else begin
            pm1_r    <= p_r - ONE;
            e_r      <= p_r - ONE;
            pw_run_r <= '0;
            cnt_r    <= CNT_LAST;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring remainder of the seed by p-1, most significant seed bit first.
          pw_run_r <= au_res;
          if (cnt_r == '0) begin
            state_r <= S_ODD;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_ODD: begin
          if (!e_r[0]) begin
            e_r <= e_r >> 1;
          end else begin
            exp_r    <= e_r;
            pw_acc_r <= ONE;
            pw_run_r <= pw_run_r + ONE;
            state_r  <= S_POW;
          end
        end
        S_POW: begin
          if (e_r == '0) begin
            state_r <= S_SQCHK;
          end else if (e_r[0]) begin
            mm_acc_r <= '0;
            mm_run_r <= pw_run_r;
            mm_b_r   <= pw_acc_r;
            ph_r     <= 1'b0;
            dest_r   <= DST_ACC;
            ret_r    <= S_POWSQ;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_POWSQ;
          end
        end
        S_POWSQ: begin
          e_r <= e_r >> 1;
          // The base is squared only when more exponent bits remain.
          if (e_r[W-1:1] != '0) begin
            mm_acc_r <= '0;
            mm_run_r <= pw_run_r;
            mm_b_r   <= pw_run_r;
            ph_r     <= 1'b0;
            dest_r   <= DST_RUN;
            ret_r    <= S_POW;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_POW;
          end
        end
        S_MUL: begin
          if (mm_b_r == '0) begin
            if (dest_r == DST_ACC) begin
              pw_acc_r <= mm_acc_r;
            end else begin
              pw_run_r <= mm_acc_r;
            end
            state_r <= ret_r;
          end else if (mm_add) begin
            mm_acc_r <= au_res;
            ph_r     <= 1'b1;
          end else begin
            mm_run_r <= au_res;
            mm_b_r   <= mm_b_r >> 1;
            ph_r     <= 1'b0;
          end
        end
        S_SQCHK: begin
          if (exp_r != pm1_r && pw_acc_r != ONE && pw_acc_r != pm1_r) begin
            exp_r    <= exp_r << 1;
            mm_acc_r <= '0;
            mm_run_r <= pw_acc_r;
            mm_b_r   <= pw_acc_r;
            ph_r     <= 1'b0;
            dest_r   <= DST_ACC;
            ret_r    <= S_SQCHK;
            state_r  <= S_MUL;
          end else begin
            verd_r  <= (pw_acc_r == pm1_r) || exp_r[0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            pp_r        <= still_r && verd_r;
            fin_r       <= last_r;
            still_r     <= last_r || (still_r && verd_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mrpt_checker.sv =====
// Port-level assertions for the Miller-Rabin block and the bind that attaches them.
module mrpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_probably_prime,
  input logic out_final_res
);

  // A stalled verdict stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probably_prime) &&
                                $stable(out_final_res))
    else $error("stalled verdict changed or was dropped");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The block works on one item at a time, so it is busy after every input transfer.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A new verdict only comes out of a round in work, never from the idle state.
  a_verdict_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("verdict appeared while the block was idle");

endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_probably_prime (out_chan.probably_prime),
  .out_final_res      (out_chan.final_res)
);

// ===== tb/tb_miller_rabin_primality_test.sv =====
// Self-checking testbench for the Miller-Rabin primality test block.
module tb_miller_rabin_primality_test;
  import mrpt_pkg::*;

  localparam int NUM_W       = 64;
  localparam int RAND_ITEMS  = 77;
  localparam int HOLD_CYCLES = 40000;
  localparam int HOLD_AFTER  = 40;
  localparam int DRAIN_WAIT  = 200;
  localparam int STALL_LIMIT = 200000;

  typedef logic [CAND_EXT_W-1:0] word_t;

  localparam word_t NUM_MASK = {CAND_EXT_W{1'b1}} >> (CAND_EXT_W - NUM_W);

  typedef struct packed {
    cand_t cand;
    seed_t seed;
    logic  last;
  } round_req_t;

  typedef struct packed {
    logic probably_prime;
    logic final_res;
  } verdict_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRD} rx_mode_t;

  logic clk;
  logic rst_n;

  mrpt_in_if  in_ch ();
  mrpt_out_if out_ch ();

  miller_rabin_primality_test #(.NUM_WIDTH(NUM_W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  round_req_t pending_rounds[$];
  verdict_t   expected_verdicts[$];
  int         queued_rounds;
  int         errors;
  int         verdicts_seen;
  int         idle_cycles;

  cand_t small_primes [11] = '{63'd3, 63'd5, 63'd7, 63'd11, 63'd13, 63'd97, 63'd101,
                               63'd7919, 63'd65521, 63'd65537, 63'd1000003};
  cand_t big_primes [6] = '{63'd2147483647, 63'd4294967291, 63'd1000000007,
                            63'd998244353, 63'd2305843009213693951,
                            63'd9223372036854775783};
  cand_t pseudoprimes [14] = '{63'd561, 63'd1105, 63'd1729, 63'd2465, 63'd2821, 63'd6601,
                               63'd2047, 63'd3277, 63'd4033, 63'd4681, 63'd8321,
                               63'd25326001, 63'd3215031751,
                               63'd3825123056546413051};

  // Modular sum of two residues below m, written so that it cannot overflow.
  function automatic word_t sum_mod(word_t x, word_t y, word_t m);
    word_t gap;
    gap = m - y;
    if (x >= gap) return x - gap;
    return x + y;
  endfunction

  function automatic word_t prod_mod(word_t a, word_t b, word_t m);
    word_t acc, run, mult;
    acc  = '0;
    run  = a % m;
    mult = b;
    while (mult != '0) begin
      if (mult[0]) acc = sum_mod(acc, run, m);
      run  = sum_mod(run, run, m);
      mult = mult >> 1;
    end
    return acc;
  endfunction

  function automatic word_t power_mod(word_t a, word_t e, word_t m);
    word_t acc, run, ex;
    acc = word_t'(1) % m;
    run = a % m;
    ex  = e;
    while (ex != '0) begin
      if (ex[0]) acc = prod_mod(acc, run, m);
      run = prod_mod(run, run, m);
      ex  = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic witness_round_ok(word_t p, seed_t seed);
    word_t pm1, odd_part, ex, x, base;
    if (p < 2) return 1'b0;
    if (p != 2 && !p[0]) return 1'b0;
    pm1      = p - 1;
    odd_part = pm1;
    while (!odd_part[0]) odd_part = odd_part >> 1;
    base = word_t'(seed) % pm1 + 1;
    ex   = odd_part;
    x    = power_mod(base, ex, p);
    while (ex != pm1 && x != 1 && x != pm1) begin
      x  = prod_mod(x, x, p);
      ex = ex << 1;
    end
    if (x != pm1 && !ex[0]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic cand_t rand_wide();
    return cand_t'({$urandom, $urandom});
  endfunction

  // Arbitrary values of random bit length, even or odd, for noise rounds.
  function automatic cand_t noise_candidate();
    return rand_wide() >> $urandom_range(0, CAND_W - 1);
  endfunction

  function automatic cand_t pick_candidate();
    cand_t c;
    case ($urandom_range(0, 9))
      0, 1: c = small_primes[$urandom_range(0, 10)];
      2:    c = big_primes[$urandom_range(0, 5)];
      3:    c = pseudoprimes[$urandom_range(0, 13)];
      4, 5: c = cand_t'($urandom_range(0, 65535)) | cand_t'(1);
      6:    c = rand_wide() | cand_t'(1);
      7:    c = small_primes[$urandom_range(0, 10)] * small_primes[$urandom_range(0, 10)];
      8:    c = noise_candidate();
      default: c = cand_t'($urandom_range(0, 31));
    endcase
    return c;
  endfunction

  task automatic push_round(cand_t cand, seed_t seed, logic last);
    round_req_t r;
    r.cand = cand;
    r.seed = seed;
    r.last = last;
    pending_rounds.push_back(r);
    queued_rounds++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender: bursts of offered rounds separated by random gaps.
  int   burst_left;
  int   gap_left;
  logic prime_so_far;

  always @(posedge clk) begin
    logic     fire;
    logic     next_valid;
    word_t    p;
    verdict_t v;
    fire = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      prime_so_far = 1'b1;
      burst_left   = $urandom_range(1, 8);
      gap_left     = 0;
    end else begin
      if (fire) begin
        p = word_t'(pending_rounds[0].cand) & NUM_MASK;
        v.probably_prime = prime_so_far && witness_round_ok(p, pending_rounds[0].seed);
        v.final_res      = pending_rounds[0].last;
        expected_verdicts.push_back(v);
        prime_so_far = pending_rounds[0].last ? 1'b1 : v.probably_prime;
        void'(pending_rounds.pop_front());
      end
      // An offered round stays on the bus until its transfer.
      if (!(in_ch.valid && !fire)) begin
        if (gap_left != 0) begin
          gap_left--;
          next_valid = 1'b0;
        end else if (pending_rounds.size() != 0) begin
          next_valid = 1'b1;
          in_ch.candidate    <= pending_rounds[0].cand;
          in_ch.witness_seed <= pending_rounds[0].seed;
          in_ch.last_round   <= pending_rounds[0].last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(20, 120);
              default:    gap_left = $urandom_range(1, 12);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          next_valid = 1'b0;
        end
        in_ch.valid <= next_valid;
      end
    end
  end

  // Receiver: checks each verdict transfer and stalls on its own pattern.
  rx_mode_t rx_mode;
  int       mode_left;
  int       phase_cnt;
  int       hold_left;
  logic     hold_done;

  always @(posedge clk) begin
    verdict_t want;
    logic     next_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      phase_cnt = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual pp=%0b final=%0b",
                   $time, out_ch.probably_prime, out_ch.final_res);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.probably_prime !== want.probably_prime) begin
            $display("%0t: probably_prime mismatch, expected %0b actual %0b",
                     $time, want.probably_prime, out_ch.probably_prime);
            errors++;
          end
          if (out_ch.final_res !== want.final_res) begin
            $display("%0t: final_res mismatch, expected %0b actual %0b",
                     $time, want.final_res, out_ch.final_res);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && verdicts_seen >= HOLD_AFTER) begin
        // Long hold-off so that the output register fills and the input stalls.
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES;
        next_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN: next_ready = 1'b1;
          RX_COIN: next_ready = 1'($urandom_range(0, 1));
          default: next_ready = (phase_cnt % 3 == 0);
        endcase
        phase_cnt++;
      end
      out_ch.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      idle_cycles <= 0;
    else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cand_t c;
    int    rounds;
    int    target;
    logic  last;
    rst_n         = 1'b0;
    queued_rounds = 0;

    // Directed: field extremes, small and even candidates, two, pseudoprimes,
    // a failure early in a test, and the verdict reset after a last round.
    push_round(63'd0, '0, 1'b1);
    push_round(63'd1, '1, 1'b1);
    push_round(63'd2, '1, 1'b1);
    push_round(63'd3, '0, 1'b1);
    push_round(63'd4, '1, 1'b1);
    push_round(63'h7FFF_FFFF_FFFF_FFFF, '1, 1'b1);
    push_round(63'h4000_0000_0000_0000, '0, 1'b1);
    push_round(63'd9223372036854775783, '0, 1'b0);
    push_round(63'd9223372036854775783, '1, 1'b1);
    push_round(63'd561, '0, 1'b0);
    push_round(63'd561, 31'd1, 1'b0);
    push_round(63'd561, 31'd100, 1'b1);
    push_round(63'd2047, '0, 1'b0);
    push_round(63'd2047, 31'd1, 1'b0);
    push_round(63'd2047, 31'd2, 1'b1);
    push_round(63'd9, 31'd7, 1'b0);
    push_round(63'd7, 31'd3, 1'b0);
    push_round(63'd7, 31'd5, 1'b1);
    push_round(63'd2305843009213693951, seed_t'($urandom), 1'b1);
    push_round(63'd3825123056546413051, 31'd1, 1'b1);
    push_round(63'd5, 31'd3, 1'b1);
    push_round(63'd2, 31'd0, 1'b0);
    push_round(63'd15, 31'd1, 1'b1);

    // Random: whole tests of several rounds, with noise and broken sequences.
    target = queued_rounds + RAND_ITEMS;
    while (queued_rounds < target) begin
      c      = pick_candidate();
      rounds = $urandom_range(1, 4);
      for (int r = 0; r < rounds; r++) begin
        if ($urandom_range(0, 19) == 0) c = noise_candidate();
        last = (r == rounds - 1);
        if (last && $urandom_range(0, 9) == 0) last = 1'b0;
        push_round(c, seed_t'($urandom), last);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_rounds.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
